// ----- hdl/amdfs_pkg.sv -----
// Shared constants and request codes for the adjacency matrix DFS block.
package amdfs_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    localparam int VERTEX_W  = 4;
    localparam int REQ_W     = 2;
    localparam int WEIGHT_W  = 16;
    localparam int VCOUNT_W  = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_ADD    = 2'd0;
    localparam t_req REQ_REMOVE = 2'd1;
    localparam t_req REQ_QUERY  = 2'd2;
    localparam t_req REQ_DFS    = 2'd3;

    localparam logic CFG_VCOUNT = 1'b0;
    localparam logic CFG_DIR    = 1'b1;

endpackage

// ----- hdl/adjacency_matrix_dfs.sv -----
// Adjacency bit matrix with edge update, edge query and depth-first traversal.
// Add/remove: read and write back the row, then the mirror row when undirected; query: read, then
// answer. Traversal: one row scan bit per cycle (held while a hit waits on the result stream) from
// a resume point kept on the stack; each vertex entered or popped on backtrack re-reads its row.
// One request at a time; the next is taken once the sequencer is back to idle.
// Synchronous active-low reset clears the row valid bits (no edges), vertex count 16, undirected.
module adjacency_matrix_dfs #(
    parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [amdfs_pkg::VCOUNT_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] req_type, [5:2] from_vertex, [9:6] to_vertex, [25:10] edge_weight
    input  logic [amdfs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [3:0] visit_vertex, [4] edge_present
    output logic [amdfs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] range_error
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int VW  = amdfs_pkg::VERTEX_W;
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int SPW = $clog2(MAX_VERTICES + 1);
    localparam int CW  = (amdfs_pkg::VCOUNT_W > SPW) ? amdfs_pkg::VCOUNT_W : SPW;
    localparam int SEW = VW + SPW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_QRD  = 4'd2;
    localparam logic [3:0] S_QOUT = 4'd3;
    localparam logic [3:0] S_ARD1 = 4'd4;
    localparam logic [3:0] S_AWR1 = 4'd5;
    localparam logic [3:0] S_ARD2 = 4'd6;
    localparam logic [3:0] S_AWR2 = 4'd7;
    localparam logic [3:0] S_DROW = 4'd8;
    localparam logic [3:0] S_DSCN = 4'd9;
    localparam logic [3:0] S_DPOP = 4'd10;
    localparam logic [3:0] S_DFIN = 4'd11;

    // configuration
    logic [amdfs_pkg::VCOUNT_W-1:0] r_vcount;
    logic                           r_dir;

    // sequencer
    logic [3:0]              r_state, n_state;
    logic [VW-1:0]           r_u, n_u;
    logic [VW-1:0]           r_v, n_v;
    logic                    r_on, n_on;
    logic [VW-1:0]           r_top, n_top;
    logic [SPW-1:0]          r_idx, n_idx;
    logic [SPW-1:0]          r_ret, n_ret;
    logic [SPW-1:0]          r_sp, n_sp;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [VW-1:0]           r_pend, n_pend;

    // output register
    logic          r_out_valid;
    logic [VW-1:0] r_out_vis;
    logic          r_out_edge;
    logic          r_out_err;
    logic          r_out_last;

    // matrix memory
    logic [MAX_VERTICES-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_rd_q;
    logic                    r_rd_vld;
    logic                    mem_re, mem_we;
    logic [IW-1:0]           mem_raddr, mem_waddr, mem_bit;
    logic [MAX_VERTICES-1:0] mem_wdata, row_q;

    // traversal stack memory: {resume index of parent, vertex}
    logic [SEW-1:0] r_stk [MAX_VERTICES];
    logic [SEW-1:0] r_stk_q;
    logic           stk_re, stk_we;
    logic [IW-1:0]  stk_raddr, stk_waddr;
    logic [SEW-1:0] stk_wdata;

    // output load
    logic          emit;
    logic [VW-1:0] emit_vis;
    logic          emit_edge, emit_err, emit_last;
    logic          slot_free;

    logic [CW-1:0]  cnt_eff;
    logic           acc;
    amdfs_pkg::t_req in_req;
    logic [VW-1:0]  in_from, in_to;
    logic [amdfs_pkg::WEIGHT_W-1:0] in_weight;
    logic           from_ok, to_ok;
    logic           scan_done, scan_hit;
    logic [SPW-1:0] sp_m2, idx_p1;

    assign in_req    = s_axis_tdata[1:0];
    assign in_from   = s_axis_tdata[5:2];
    assign in_to     = s_axis_tdata[9:6];
    assign in_weight = s_axis_tdata[25:10];

    assign cnt_eff = (CW'(r_vcount) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(r_vcount);
    assign from_ok = CW'(in_from) < cnt_eff;
    assign to_ok   = CW'(in_to) < cnt_eff;

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;

    assign row_q     = r_rd_vld ? r_rd_q : '0;
    assign scan_done = !(CW'(r_idx) < cnt_eff);
    assign scan_hit  = row_q[r_idx[IW-1:0]] && !r_visited[r_idx[IW-1:0]];
    assign sp_m2     = r_sp - SPW'(2);
    assign idx_p1    = r_idx + SPW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= amdfs_pkg::VCOUNT_RESET;
            r_dir    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                amdfs_pkg::CFG_VCOUNT: r_vcount <= i_cfg_wdata;
                amdfs_pkg::CFG_DIR:    r_dir    <= i_cfg_wdata[0];
                default:               r_vcount <= r_vcount;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_u       = r_u;
        n_v       = r_v;
        n_on      = r_on;
        n_top     = r_top;
        n_idx     = r_idx;
        n_ret     = r_ret;
        n_sp      = r_sp;
        n_visited = r_visited;
        n_pend    = r_pend;
        mem_re    = 1'b0;
        mem_raddr = IW'(r_u);
        mem_we    = 1'b0;
        mem_waddr = IW'(r_u);
        mem_bit   = IW'(r_v);
        stk_re    = 1'b0;
        stk_raddr = sp_m2[IW-1:0];
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = {SPW'(0), in_from};
        emit      = 1'b0;
        emit_vis  = '0;
        emit_edge = 1'b0;
        emit_err  = 1'b0;
        emit_last = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_u  = in_from;
                    n_v  = in_to;
                    n_on = (in_req == amdfs_pkg::REQ_ADD) && (in_weight != '0);
                    if (in_req == amdfs_pkg::REQ_DFS) begin
                        if (!from_ok) begin
                            n_state = S_ERR;
                        end else begin
                            n_visited = '0;
                            n_visited[IW'(in_from)] = 1'b1;
                            stk_we  = 1'b1;
                            n_sp    = SPW'(1);
                            n_top   = in_from;
                            n_idx   = '0;
                            n_ret   = '0;
                            n_pend  = in_from;
                            n_state = S_DROW;
                        end
                    end else if (!(from_ok && to_ok)) begin
                        n_state = S_ERR;
                    end else if (in_req == amdfs_pkg::REQ_QUERY) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_ARD1;
                    end
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_err  = 1'b1;
                    emit_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_QRD: begin
                mem_re  = 1'b1;
                n_state = S_QOUT;
            end
            S_QOUT: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_edge = row_q[IW'(r_v)];
                    emit_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_ARD1: begin
                mem_re  = 1'b1;
                n_state = S_AWR1;
            end
            S_AWR1: begin
                mem_we  = 1'b1;
                n_state = r_dir ? S_IDLE : S_ARD2;
            end
            S_ARD2: begin
                // mirror entry
                mem_re    = 1'b1;
                mem_raddr = IW'(r_v);
                n_state   = S_AWR2;
            end
            S_AWR2: begin
                mem_we    = 1'b1;
                mem_waddr = IW'(r_v);
                mem_bit   = IW'(r_u);
                n_state   = S_IDLE;
            end
            S_DROW: begin
                mem_re    = 1'b1;
                mem_raddr = IW'(r_top);
                n_state   = S_DSCN;
            end
            S_DSCN: begin
                if (scan_done) begin
                    if (r_sp == SPW'(1)) begin
                        n_state = S_DFIN;
                    end else begin
                        // backtrack: fetch the parent and resume its scan
                        stk_re  = 1'b1;
                        n_sp    = r_sp - SPW'(1);
                        n_idx   = r_ret;
                        n_state = S_DPOP;
                    end
                end else if (scan_hit) begin
                    if (slot_free) begin
                        emit      = 1'b1;
                        emit_vis  = r_pend;
                        n_pend    = VW'(r_idx);
                        n_visited[r_idx[IW-1:0]] = 1'b1;
                        if (r_sp < SPW'(MAX_VERTICES)) begin
                            stk_we    = 1'b1;
                            stk_waddr = r_sp[IW-1:0];
                            stk_wdata = {idx_p1, VW'(r_idx)};
                            n_sp      = r_sp + SPW'(1);
                            n_top     = VW'(r_idx);
                            n_ret     = idx_p1;
                            n_idx     = '0;
                            n_state   = S_DROW;
                        end else begin
                            n_idx = idx_p1;
                        end
                    end
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_DPOP: begin
                n_top   = r_stk_q[VW-1:0];
                n_ret   = r_stk_q[SEW-1:VW];
                n_state = S_DROW;
            end
            S_DFIN: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_vis  = r_pend;
                    emit_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_wdata          = row_q;
        mem_wdata[mem_bit] = r_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= emit || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_u       <= n_u;
        r_v       <= n_v;
        r_on      <= n_on;
        r_top     <= n_top;
        r_idx     <= n_idx;
        r_ret     <= n_ret;
        r_visited <= n_visited;
        r_pend    <= n_pend;
        if (emit) begin
            r_out_vis  <= emit_vis;
            r_out_edge <= emit_edge;
            r_out_err  <= emit_err;
            r_out_last <= emit_last;
        end
    end

    // matrix rows: never-written rows read as no edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (mem_we) begin
            r_row_vld[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_q   <= r_mem[mem_raddr];
            r_rd_vld <= r_row_vld[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_q <= r_stk[stk_raddr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(amdfs_pkg::OUT_DATA_W - VW - 1){1'b0}}, r_out_edge, r_out_vis};
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(MAX_VERTICES))
        else $error("stack pointer beyond capacity");

    a_dfs_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROW || r_state == S_DSCN || r_state == S_DPOP) |-> r_sp != '0)
        else $error("traversal running with an empty stack");

    a_visited_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSCN) |-> (CW'($countones(r_visited)) <= cnt_eff))
        else $error("more vertices visited than in use");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("range error beat carries data or is not last");

endmodule
